/* hdl/olv_pkg.sv */
// Shared types, constants and pipeline depths for the orbit look-at view block.
// Used by every module under hdl; depends on nothing else.
package olv_pkg;

  localparam int ANGLE_BITS_DEF = 16;

  localparam logic [29:0] PI4_Q30 = 30'd843314857;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic signed [15:0] UNIT14 = 16'sd16384;

  localparam int HORNER_STEPS = 5;
  localparam int SIN_STEPS = 4;

  localparam logic [30:0] SIN_MUL [SIN_STEPS] = '{
    31'(((64'd1 << 37) + 64'd71) / 64'd72),
    31'(((64'd1 << 36) + 64'd41) / 64'd42),
    31'(((64'd1 << 35) + 64'd19) / 64'd20),
    31'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam int SIN_SH [SIN_STEPS] = '{37, 36, 35, 33};

  localparam logic [30:0] COS_MUL [HORNER_STEPS] = '{
    31'(((64'd1 << 37) + 64'd89) / 64'd90),
    31'(((64'd1 << 36) + 64'd55) / 64'd56),
    31'(((64'd1 << 35) + 64'd29) / 64'd30),
    31'(((64'd1 << 34) + 64'd11) / 64'd12),
    31'(((64'd1 << 31) + 64'd1) / 64'd2)
  };
  localparam int COS_SH [HORNER_STEPS] = '{37, 36, 35, 34, 31};

  localparam int ISQ_PER = 2;
  localparam int ISQ_ST = 32 / ISQ_PER;
  localparam int QBITS = 15;
  localparam int DIV_PER = 3;
  localparam int DIV_ST = QBITS / DIV_PER;

  localparam int SC_LAT = 2 + 2 * HORNER_STEPS;
  localparam int U3_LAT = 6 + ISQ_ST + 1 + DIV_ST + 1;
  localparam int FR_LAT = 6;
  localparam int TOP_LAT = SC_LAT + 2 + U3_LAT + FR_LAT;

  typedef struct packed {
    logic [31:0]        orbit_radius;
    logic [15:0]        orbit_angle;
    logic signed [31:0] eye_height;
    logic signed [31:0] target_height;
  } olv_in_t;

  typedef struct packed {
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] upward_x;
    logic signed [15:0] upward_y;
    logic signed [15:0] upward_z;
    logic signed [15:0] back_x;
    logic signed [15:0] back_y;
    logic signed [15:0] back_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } olv_out_t;

  typedef struct packed {
    logic signed [32:0] px;
    logic signed [32:0] pz;
    logic signed [31:0] h;
    logic               vert;
    logic               dneg;
  } olv_cam_t;

endpackage

/* hdl/orbit_look_at_view_matrix.sv */
// Orbit camera look-at view matrix: rotation rows and saturated translation.
// One request is accepted per cycle, and each accepted request yields one result on out_valid.
// The sine/cosine, square root and divider pipelines never stall, so they allow that rate.
// busy stays low: a request is taken in every cycle and each result shows for one cycle.
// Synchronous reset clears all valid bits; data registers are not reset.
// Depends on olv_pkg, olv_sincos, olv_unit3 and olv_frame.
module orbit_look_at_view_matrix #(
  parameter int ANGLE_BITS = olv_pkg::ANGLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  olv_pkg::olv_in_t  in_req,
  output logic              out_valid,
  output olv_pkg::olv_out_t out_res
);
  import olv_pkg::*;

  localparam int SC_TAG = 96;
  localparam int CAM_W = $bits(olv_cam_t);

  logic              acc;
  logic [ANGLE_BITS-1:0] ang;
  logic              sc_v;
  logic [30:0]       sc_sin, sc_cos;
  logic              sc_sneg, sc_cneg;
  logic [SC_TAG-1:0] sc_tag;

  assign busy = 1'b0;
  assign acc = start && !busy;
  assign ang = ANGLE_BITS'(in_req.orbit_angle);

  olv_sincos #(.ANGLE_BITS(ANGLE_BITS), .TAG_W(SC_TAG)) u_sincos (
    .clk(clk), .rst_n(rst_n), .valid_i(acc), .angle_i(ang),
    .tag_i({in_req.orbit_radius, in_req.eye_height, in_req.target_height}),
    .valid_o(sc_v), .sin_o(sc_sin), .cos_o(sc_cos), .sneg_o(sc_sneg), .cneg_o(sc_cneg),
    .tag_o(sc_tag)
  );

  logic        p1_v_r, p2_v_r;
  logic [31:0] pxm_r, pzm_r;
  logic        sneg_r, cneg_r;
  logic [31:0] h1_r, t1_r;
  logic [63:0] pxp, pzp;
  olv_cam_t    cam_r;
  logic signed [32:0] dy_r;
  logic signed [32:0] pxs, pzs, dy;

  always_comb begin
    pxp = 64'(sc_tag[95:64]) * 64'(sc_sin) + (64'd1 << 29);
    pzp = 64'(sc_tag[95:64]) * 64'(sc_cos) + (64'd1 << 29);
    pxs = sneg_r ? -$signed({1'b0, pxm_r}) : $signed({1'b0, pxm_r});
    pzs = cneg_r ? -$signed({1'b0, pzm_r}) : $signed({1'b0, pzm_r});
    dy = $signed({h1_r[31], h1_r}) - $signed({t1_r[31], t1_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= sc_v;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    pxm_r <= pxp[61:30];
    pzm_r <= pzp[61:30];
    sneg_r <= sc_sneg;
    cneg_r <= sc_cneg;
    h1_r <= sc_tag[63:32];
    t1_r <= sc_tag[31:0];
    cam_r <= '{px: pxs, pz: pzs, h: h1_r, vert: (pxm_r == 32'd0) && (pzm_r == 32'd0),
               dneg: dy < 0};
    dy_r <= dy;
  end

  logic             az_v;
  logic [2:0][15:0] az_q, ax_q;
  logic [CAM_W-1:0] cam_tag;
  logic signed [32:0] npx;

  assign npx = -cam_r.px;

  olv_unit3 #(.TAG_W(CAM_W)) u_unit_back (
    .clk(clk), .rst_n(rst_n), .valid_i(p2_v_r),
    .v_i({cam_r.pz, dy_r, cam_r.px}), .tag_i(cam_r),
    .valid_o(az_v), .q_o(az_q), .tag_o(cam_tag)
  );

  olv_unit3 #(.TAG_W(1)) u_unit_right (
    .clk(clk), .rst_n(rst_n), .valid_i(p2_v_r),
    .v_i({npx, 33'sd0, cam_r.pz}), .tag_i(1'b0),
    .valid_o(), .q_o(ax_q), .tag_o()
  );

  olv_frame u_frame (
    .clk(clk), .rst_n(rst_n), .valid_i(az_v), .az_i(az_q), .ax_i(ax_q),
    .cam_i(olv_cam_t'(cam_tag)), .valid_o(out_valid), .res_o(out_res)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##TOP_LAT out_valid)
    else $error("accepted request produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, TOP_LAT))
    else $error("result without a matching request");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised although every request is taken");

endmodule

/* hdl/olv_sincos.sv */
// Pipelined sine and cosine of a binary angle, Q30 magnitudes with octant signs.
// Uses olv_pkg for the Horner divisor reciprocals and constants.
module olv_sincos #(
  parameter int ANGLE_BITS = olv_pkg::ANGLE_BITS_DEF,
  parameter int TAG_W = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  input  logic [TAG_W-1:0]      tag_i,
  output logic                  valid_o,
  output logic [30:0]           sin_o,
  output logic [30:0]           cos_o,
  output logic                  sneg_o,
  output logic                  cneg_o,
  output logic [TAG_W-1:0]      tag_o
);
  import olv_pkg::*;

  localparam int OSZ_BITS = ANGLE_BITS - 3;
  localparam int U_W = OSZ_BITS + 1;
  localparam int NSC = 2 * HORNER_STEPS + 1;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic        swap;
    logic        sneg;
    logic        cneg;
  } sc_t;

  logic [2:0]          oct;
  logic [OSZ_BITS-1:0] off;
  logic [U_W-1:0]      u;
  logic [U_W+29:0]     ux;

  always_comb begin
    oct = angle_i[ANGLE_BITS-1 -: 3];
    off = angle_i[OSZ_BITS-1:0];
    u = oct[0] ? ((U_W'(1) << OSZ_BITS) - U_W'(off)) : U_W'(off);
    ux = (U_W + 30)'(u) * (U_W + 30)'(PI4_Q30);
  end

  logic             v0_r;
  logic [29:0]      x0_r;
  logic [2:0]       oct0_r;
  logic [TAG_W-1:0] tag0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= ux[OSZ_BITS +: 30];
    oct0_r <= oct;
    tag0_r <= tag_i;
  end

  logic [59:0]      xx;
  sc_t              sc_r [NSC];
  logic [NSC-1:0]   v_r;
  logic [TAG_W-1:0] tag_r [NSC];

  assign xx = 60'(x0_r) * 60'(x0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NSC-2:0], v0_r};
    end
  end

  always_ff @(posedge clk) begin
    sc_r[0] <= '{x: x0_r, x2: xx[59:30], swap: oct0_r[0] ^ oct0_r[1],
                 sneg: oct0_r[2], cneg: oct0_r[1] ^ oct0_r[2]};
    tag_r[0] <= tag0_r;
    for (int k = 1; k < NSC; k++) begin
      sc_r[k] <= sc_r[k-1];
      tag_r[k] <= tag_r[k-1];
    end
  end

  logic [30:0] tc_r [HORNER_STEPS];
  logic [30:0] ts_r [HORNER_STEPS];
  logic [29:0] pc_r [HORNER_STEPS];
  logic [29:0] ps_r [HORNER_STEPS];

  for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_hs
    logic [30:0] tcin;
    logic [30:0] tsin;
    logic [29:0] sop;
    logic [60:0] mc;
    logic [60:0] ms;
    logic [60:0] dc;
    logic [30:0] qc;

    if (j == 0) begin : g_first
      assign tcin = Q30_ONE;
      assign tsin = Q30_ONE;
    end else begin : g_next
      assign tcin = tc_r[j-1];
      assign tsin = ts_r[j-1];
    end

    assign sop = (j < SIN_STEPS) ? sc_r[2*j].x2 : sc_r[2*j].x;
    assign mc = 61'(sc_r[2*j].x2) * 61'(tcin);
    assign ms = 61'(sop) * 61'(tsin);

    always_ff @(posedge clk) begin
      pc_r[j] <= mc[59:30];
      ps_r[j] <= ms[59:30];
    end

    assign dc = 61'(pc_r[j]) * 61'(COS_MUL[j]);
    assign qc = 31'(dc >> COS_SH[j]);

    always_ff @(posedge clk) begin
      tc_r[j] <= Q30_ONE - qc;
    end

    if (j < SIN_STEPS) begin : g_sdiv
      logic [60:0] ds;
      logic [30:0] qs;
      assign ds = 61'(ps_r[j]) * 61'(SIN_MUL[j]);
      assign qs = 31'(ds >> SIN_SH[j]);
      always_ff @(posedge clk) begin
        ts_r[j] <= Q30_ONE - qs;
      end
    end else begin : g_sfin
      always_ff @(posedge clk) begin
        ts_r[j] <= (31'(ps_r[j]) > Q30_ONE) ? Q30_ONE : 31'(ps_r[j]);
      end
    end
  end

  logic [30:0] s_fin;
  logic [30:0] c_fin;

  always_comb begin
    s_fin = (ts_r[HORNER_STEPS-1] > Q30_ONE) ? Q30_ONE : ts_r[HORNER_STEPS-1];
    c_fin = (tc_r[HORNER_STEPS-1] > Q30_ONE) ? Q30_ONE : tc_r[HORNER_STEPS-1];
    sin_o = sc_r[NSC-1].swap ? c_fin : s_fin;
    cos_o = sc_r[NSC-1].swap ? s_fin : c_fin;
    sneg_o = sc_r[NSC-1].sneg;
    cneg_o = sc_r[NSC-1].cneg;
  end

  assign valid_o = v_r[NSC-1];
  assign tag_o = tag_r[NSC-1];

endmodule

/* hdl/olv_unit3.sv */
// Pipelined unit vector of a three component signed vector, Q2.14 results.
// Normalizes, takes an integer square root and divides; uses olv_pkg depths.
module olv_unit3 #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  logic [2:0][32:0] v_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [2:0][15:0] q_o,
  output logic [TAG_W-1:0] tag_o
);
  import olv_pkg::*;

  localparam int DW = TAG_W + 3;

  logic [U3_LAT-1:0] vd_r;
  logic [DW-1:0]     dl_r [U3_LAT];
  logic [2:0]        neg_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = v_i[i][32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else begin
      vd_r <= {vd_r[U3_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    dl_r[0] <= {tag_i, neg_in};
    for (int k = 1; k < U3_LAT; k++) begin
      dl_r[k] <= dl_r[k-1];
    end
  end

  logic [2:0][32:0] m1_r;
  logic [2:0][32:0] m2_r;
  logic [32:0]      mx2_r;
  logic [2:0][32:0] m3_r;
  logic [5:0]       pos3_r;
  logic [2:0][29:0] m4_r;
  logic [2:0][29:0] m5_r;
  logic [2:0][59:0] sq5_r;
  logic [32:0]      mx;
  logic [5:0]       pos;
  logic [2:0][29:0] msh;

  always_comb begin
    mx = m1_r[0];
    if (m1_r[1] > mx) begin
      mx = m1_r[1];
    end
    if (m1_r[2] > mx) begin
      mx = m1_r[2];
    end
    pos = '0;
    for (int b = 0; b < 33; b++) begin
      if (mx2_r[b]) begin
        pos = 6'(b);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (pos3_r >= 6'd30) begin
        msh[i] = 30'(m3_r[i] >> (pos3_r - 6'd29));
      end else begin
        msh[i] = 30'(62'(m3_r[i]) << (6'd29 - pos3_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m1_r[i] <= v_i[i][32] ? 33'(-$signed(v_i[i])) : v_i[i];
      sq5_r[i] <= 60'(m4_r[i]) * 60'(m4_r[i]);
    end
    m2_r <= m1_r;
    mx2_r <= mx;
    m3_r <= m2_r;
    pos3_r <= pos;
    m4_r <= msh;
    m5_r <= m4_r;
  end

  logic [63:0]      sqx_r [ISQ_ST+1];
  logic [63:0]      sqr_r [ISQ_ST+1];
  logic [2:0][29:0] sqm_r [ISQ_ST+1];

  always_ff @(posedge clk) begin
    sqx_r[0] <= 64'(sq5_r[0]) + 64'(sq5_r[1]) + 64'(sq5_r[2]);
    sqr_r[0] <= '0;
    sqm_r[0] <= m5_r;
  end

  for (genvar g = 0; g < ISQ_ST; g++) begin : g_isq
    logic [63:0] xv;
    logic [63:0] rv;
    logic [63:0] bt;

    always_comb begin
      xv = sqx_r[g];
      rv = sqr_r[g];
      bt = '0;
      for (int s = 0; s < ISQ_PER; s++) begin
        bt = 64'd1 << (62 - 2 * (ISQ_PER * g + s));
        if (xv >= rv + bt) begin
          xv = xv - (rv + bt);
          rv = (rv >> 1) + bt;
        end else begin
          rv = rv >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      sqx_r[g+1] <= xv;
      sqr_r[g+1] <= rv;
      sqm_r[g+1] <= sqm_r[g];
    end
  end

  logic [2:0][45:0]      rem_r [DIV_ST+1];
  logic [2:0][QBITS-1:0] qd_r  [DIV_ST+1];
  logic [31:0]           den_r [DIV_ST+1];
  logic [30:0]           nroot;

  assign nroot = sqr_r[ISQ_ST][30:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rem_r[0][i] <= {1'b0, sqm_r[ISQ_ST][i], 15'd0} + 46'(nroot);
    end
    qd_r[0] <= '0;
    den_r[0] <= {nroot, 1'b0};
  end

  for (genvar g = 0; g < DIV_ST; g++) begin : g_div
    logic [2:0][45:0]      rv;
    logic [2:0][QBITS-1:0] qv;
    logic [46:0]           trial;

    always_comb begin
      rv = rem_r[g];
      qv = qd_r[g];
      trial = '0;
      for (int i = 0; i < 3; i++) begin
        for (int s = 0; s < DIV_PER; s++) begin
          trial = 47'(den_r[g]) << (QBITS - 1 - (DIV_PER * g + s));
          if (47'(rv[i]) >= trial) begin
            rv[i] = 46'(47'(rv[i]) - trial);
            qv[i][QBITS - 1 - (DIV_PER * g + s)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g+1] <= rv;
      qd_r[g+1] <= qv;
      den_r[g+1] <= den_r[g];
    end
  end

  logic [2:0][15:0] q_r;
  logic [2:0]       neg_d;

  assign neg_d = dl_r[U3_LAT-2][2:0];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q_r[i] <= neg_d[i] ? -16'(qd_r[DIV_ST][i]) : 16'(qd_r[DIV_ST][i]);
    end
  end

  assign valid_o = vd_r[U3_LAT-1];
  assign q_o = q_r;
  assign tag_o = dl_r[U3_LAT-1][DW-1:3];

endmodule

/* hdl/olv_frame.sv */
// Up axis cross product, vertical fallback basis and saturated translation.
// Takes the two unit axes and the eye position; uses olv_pkg types.
module olv_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  logic [2:0][15:0]    az_i,
  input  logic [2:0][15:0]    ax_i,
  input  olv_pkg::olv_cam_t   cam_i,
  output logic                valid_o,
  output olv_pkg::olv_out_t   res_o
);
  import olv_pkg::*;

  function automatic logic signed [51:0] rs14(input logic signed [51:0] v);
    logic [51:0] mag;
    mag = v[51] ? 52'(-v) : 52'(v);
    mag = (mag + 52'd8192) >> 14;
    return v[51] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [15:0] clamp_unit(input logic signed [51:0] v);
    logic [15:0] r;
    if (v > 52'sd16384) begin
      r = UNIT14;
    end else if (v < -52'sd16384) begin
      r = -UNIT14;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  logic [FR_LAT-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[FR_LAT-2:0], valid_i};
    end
  end

  logic [2:0][15:0] az1_r, ax1_r, az2_r, ax2_r;
  logic [15:0]      sy1_r, sy2_r;
  logic             vert1_r, vert2_r, vert3_r, vert4_r, vert5_r, vert6_r;
  logic [2:0][32:0] p1_r, p2_r, p3_r;
  logic [2:0][32:0] prod2_r;
  logic [2:0][2:0][15:0] rows3_r, rows4_r, rows5_r;
  logic [2:0][2:0][48:0] pr4_r;
  logic [2:0][51:0] nd5_r;
  olv_out_t         res_r;
  logic [15:0]      sy;
  logic signed [15:0] zx, zy, zz, xx, xz;
  logic [2:0][15:0] ay;
  logic [2:0][51:0] dsum;
  logic [2:0][31:0] sh;
  logic signed [51:0] rv;

  always_comb begin
    sy = cam_i.dneg ? -UNIT14 : UNIT14;
    zx = az1_r[0];
    zy = az1_r[1];
    zz = az1_r[2];
    xx = ax1_r[0];
    xz = ax1_r[2];
    for (int i = 0; i < 3; i++) begin
      ay[i] = clamp_unit(rs14(52'($signed(prod2_r[i]))));
    end
    if (vert2_r) begin
      ay = {16'd0, 16'd0, sy2_r};
    end
    for (int k = 0; k < 3; k++) begin
      dsum[k] = 52'($signed(pr4_r[k][0])) + 52'($signed(pr4_r[k][1]))
              + 52'($signed(pr4_r[k][2]));
    end
    for (int k = 0; k < 3; k++) begin
      rv = rs14($signed(nd5_r[k]));
      if (rv > 52'sd2147483647) begin
        sh[k] = 32'h7fff_ffff;
      end else if (rv < -52'sd2147483648) begin
        sh[k] = 32'h8000_0000;
      end else begin
        sh[k] = 32'(rv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cam_i.vert) begin
      az1_r <= {16'd0, sy, 16'd0};
      ax1_r <= {UNIT14, 16'd0, 16'd0};
    end else begin
      az1_r <= az_i;
      ax1_r <= ax_i;
    end
    sy1_r <= sy;
    vert1_r <= cam_i.vert;
    p1_r <= {cam_i.pz, 33'($signed(cam_i.h)), cam_i.px};

    prod2_r[0] <= 33'(zy) * 33'(xz);
    prod2_r[1] <= 33'(zz) * 33'(xx) - 33'(zx) * 33'(xz);
    prod2_r[2] <= -(33'(zy) * 33'(xx));
    az2_r <= az1_r;
    ax2_r <= ax1_r;
    sy2_r <= sy1_r;
    vert2_r <= vert1_r;
    p2_r <= p1_r;

    rows3_r <= {az2_r, ay, ax2_r};
    vert3_r <= vert2_r;
    p3_r <= p2_r;

    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        pr4_r[k][i] <= 49'($signed(rows3_r[k][i])) * 49'($signed(p3_r[i]));
      end
    end
    rows4_r <= rows3_r;
    vert4_r <= vert3_r;

    for (int k = 0; k < 3; k++) begin
      nd5_r[k] <= -dsum[k];
    end
    rows5_r <= rows4_r;
    vert5_r <= vert4_r;

    res_r <= '{right_x: rows5_r[0][0], right_y: rows5_r[0][1], right_z: rows5_r[0][2],
               upward_x: rows5_r[1][0], upward_y: rows5_r[1][1], upward_z: rows5_r[1][2],
               back_x: rows5_r[2][0], back_y: rows5_r[2][1], back_z: rows5_r[2][2],
               shift_x: sh[0], shift_y: sh[1], shift_z: sh[2]};
    vert6_r <= vert5_r;
  end

  assign valid_o = v_r[FR_LAT-1];
  assign res_o = res_r;

  a_right_flat: assert property (@(posedge clk) disable iff (!rst_n)
    valid_o |-> res_r.right_y == 16'sd0)
    else $error("right axis has a vertical component");

  a_vert_basis: assert property (@(posedge clk) disable iff (!rst_n)
    valid_o && vert6_r |-> res_r.right_x == 16'sd0 && res_r.right_z == UNIT14
                           && res_r.back_x == 16'sd0 && res_r.back_z == 16'sd0)
    else $error("vertical view does not use the fixed basis");

endmodule
